### rtl/core/ttgp_pkg.sv
// Shared types, constants and the sine-squared table for the tilt-to-grid core.
`default_nettype none
package ttgp_pkg;

  localparam int GRID_SIZE_DEF   = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int GRID_W          = 3;
  localparam int DEG_W           = 7;
  localparam int ANG_W           = 8;
  localparam int LIM_W           = 7;
  localparam int S2_W            = 31;
  localparam int Q_BITS          = 30;
  localparam int DEG_LAST        = 89;
  localparam int DEG_FULL        = 90;
  localparam int ADDR_W          = 3;

  localparam logic [LIM_W-1:0] ANGLE_LIMIT_RST = 7'd45;
  localparam logic             REG_ANGLE_LIMIT = 1'b0;

  typedef struct packed {
    logic signed [FIELD_W-1:0] accel_x;
    logic signed [FIELD_W-1:0] accel_y;
    logic signed [FIELD_W-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch_deg;
    logic signed [ANG_W-1:0] roll_deg;
    logic [GRID_W-1:0]       grid_col;
    logic [GRID_W-1:0]       grid_row;
    logic                    off_grid;
  } out_item_t;

  typedef logic [127:0][S2_W-1:0] s2_tab_t;

  // sin^2(d deg) in Q30, built by one-degree rotations with round half up
  function automatic s2_tab_t s2_table();
    longint unsigned c;
    longint unsigned s;
    longint unsigned s_n;
    longint unsigned a;
    longint unsigned b;
    longint unsigned s2;
    s2_tab_t tab;
    tab = '0;
    c = 64'd1073741824;
    s = 64'd0;
    for (int d = 1; d <= DEG_LAST; d++) begin
      a = c * 64'd1073578288;
      b = s * 64'd18739379;
      s_n = (s * 64'd1073578288 + c * 64'd18739379 + 64'd536870912) >> 30;
      c = (a >= b) ? ((a - b + 64'd536870912) >> 30) : 64'd0;
      s = s_n;
      s2 = (s * s + 64'd536870912) >> 30;
      if (d == 30) s2 = 64'd268435456;
      if (d == 45) s2 = 64'd536870912;
      if (d == 60) s2 = 64'd805306368;
      tab[d] = s2[S2_W-1:0];
    end
    return tab;
  endfunction

  localparam s2_tab_t S2_TAB = s2_table();

endpackage
`default_nettype wire

### rtl/core/ttgp_deg_step.sv
// One bit of the binary search for whole degrees of tilt.
`default_nettype none
module ttgp_deg_step #(
  parameter int BIT   = 0,
  parameter int SQ_W  = 32,
  parameter int TOT_W = 34
) (
  input  wire logic [SQ_W-1:0]               n2_i,
  input  wire logic [TOT_W-1:0]              total_i,
  input  wire logic [ttgp_pkg::DEG_W-1:0]    res_i,
  output logic      [ttgp_pkg::DEG_W-1:0]    res_o
);
  import ttgp_pkg::*;

  localparam int PROD_W = TOT_W + S2_W;

  logic [DEG_W-1:0]  trial;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic              pass;

  always_comb begin
    trial = res_i | DEG_W'(1 << BIT);
    lhs   = PROD_W'({n2_i, {Q_BITS{1'b0}}});
    rhs   = PROD_W'(total_i) * PROD_W'(S2_TAB[trial]);
    // an all-zero sample has no tilt
    pass  = (int'(trial) <= DEG_LAST) && (total_i != '0) && (lhs >= rhs);
    res_o = pass ? trial : res_i;
  end

endmodule
`default_nettype wire

### rtl/core/tilt_to_grid_position_core.sv
// Top level: pipelined accelerometer tilt angles and grid position.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_stall_o   ttgp_pkg::in_item_t
//   out       output     out_valid_o/out_stall_i ttgp_pkg::out_item_t
//   cfg       input      APB psel/penable/pready angle_limit at 0x0
//
// One transaction per cycle while the output is not stalled; the pipeline is made of the
// magnitude, square and sum stages, the seven degree-search stages, the mapping stage and the index-search stages.
// Reset clears all stage valid bits and loads angle_limit = 45.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
`default_nettype none
module tilt_to_grid_position_core #(
  parameter int GRID_SIZE   = ttgp_pkg::GRID_SIZE_DEF,
  parameter int SAMPLE_BITS = ttgp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ttgp_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output ttgp_pkg::out_item_t              out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ttgp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import ttgp_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SB;
  localparam int TOT_W  = 2 * SB + 2;
  localparam int IW     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int NUM_W  = 17;
  localparam int S_SRCH = 3;
  localparam int S_MAP  = S_SRCH + DEG_W;
  localparam int NSTG   = S_MAP + 1 + IW;

  typedef struct packed {
    logic                    neg_x;
    logic                    neg_y;
    logic [SB-1:0]           ux;
    logic [SB-1:0]           uy;
    logic [SB-1:0]           uz;
    logic [SQ_W-1:0]         x2;
    logic [SQ_W-1:0]         y2;
    logic [SQ_W-1:0]         z2;
    logic [TOT_W-1:0]        total;
    logic                    full_p;
    logic                    full_r;
    logic [DEG_W-1:0]        dp;
    logic [DEG_W-1:0]        dr;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] roll;
    logic signed [NUM_W-1:0] num_c;
    logic signed [NUM_W-1:0] num_r;
    logic signed [NUM_W-1:0] den;
    logic                    lo_c;
    logic                    hi_c;
    logic                    lo_r;
    logic                    hi_r;
    logic [IW-1:0]           ic;
    logic [IW-1:0]           ir;
  } pipe_t;

  // configuration register
  logic [LIM_W-1:0] lim_q;
  logic [LIM_W-1:0] lim_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ANGLE_LIMIT);
  assign prdata = (paddr[2] == REG_ANGLE_LIMIT) ? {{(32-LIM_W){1'b0}}, lim_q} : 32'd0;
  assign lim_eff = (lim_q == '0) ? LIM_W'(1) : lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= ANGLE_LIMIT_RST;
    end else if (cfg_wr) begin
      lim_q <= pwdata[LIM_W-1:0];
    end
  end

  // pipeline
  logic  [NSTG-1:0] v_q;
  logic  [NSTG-1:0] v_in;
  logic  [NSTG:0]   adv;
  pipe_t            st_q [NSTG];
  pipe_t            nxt  [NSTG];
  logic  [DEG_W-1:0] dp_s [DEG_W];
  logic  [DEG_W-1:0] dr_s [DEG_W];

  always_comb begin
    adv[NSTG] = !out_stall_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];
  assign v_in = {v_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) v_q[k] <= v_in[k];
      end
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    always_ff @(posedge clk_i) begin
      if (adv[k]) st_q[k] <= nxt[k];
    end
  end

  // stage 0: cast to SAMPLE_BITS, note the signs and take magnitudes
  always_comb begin
    logic signed [SB-1:0] sx;
    logic signed [SB-1:0] sy;
    logic signed [SB-1:0] sz;
    nxt[0] = '0;
    sx = SB'(unsigned'(in_data_i.accel_x));
    sy = SB'(unsigned'(in_data_i.accel_y));
    sz = SB'(unsigned'(in_data_i.accel_z));
    nxt[0].neg_x = sx[SB-1];
    nxt[0].neg_y = sy[SB-1];
    nxt[0].ux = sx[SB-1] ? SB'(-sx) : SB'(sx);
    nxt[0].uy = sy[SB-1] ? SB'(-sy) : SB'(sy);
    nxt[0].uz = sz[SB-1] ? SB'(-sz) : SB'(sz);
  end

  // stage 1: squares
  always_comb begin
    nxt[1] = st_q[0];
    nxt[1].x2 = SQ_W'(st_q[0].ux) * SQ_W'(st_q[0].ux);
    nxt[1].y2 = SQ_W'(st_q[0].uy) * SQ_W'(st_q[0].uy);
    nxt[1].z2 = SQ_W'(st_q[0].uz) * SQ_W'(st_q[0].uz);
  end

  // stage 2: sum of squares, straight-up cases
  always_comb begin
    nxt[2] = st_q[1];
    nxt[2].total = TOT_W'(st_q[1].x2) + TOT_W'(st_q[1].y2) + TOT_W'(st_q[1].z2);
    nxt[2].full_p = (st_q[1].ux != '0) && (st_q[1].uy == '0) && (st_q[1].uz == '0);
    nxt[2].full_r = (st_q[1].uy != '0) && (st_q[1].ux == '0) && (st_q[1].uz == '0);
    nxt[2].dp = '0;
    nxt[2].dr = '0;
  end

  // degree search, MSB first
  for (genvar j = 0; j < DEG_W; j++) begin : g_srch
    localparam int K = S_SRCH + j;
    ttgp_deg_step #(.BIT(DEG_W - 1 - j), .SQ_W(SQ_W), .TOT_W(TOT_W)) u_step_p (
      .n2_i    (st_q[K-1].x2),
      .total_i (st_q[K-1].total),
      .res_i   (st_q[K-1].dp),
      .res_o   (dp_s[j])
    );
    ttgp_deg_step #(.BIT(DEG_W - 1 - j), .SQ_W(SQ_W), .TOT_W(TOT_W)) u_step_r (
      .n2_i    (st_q[K-1].y2),
      .total_i (st_q[K-1].total),
      .res_i   (st_q[K-1].dr),
      .res_o   (dr_s[j])
    );
    always_comb begin
      nxt[K] = st_q[K-1];
      nxt[K].dp = dp_s[j];
      nxt[K].dr = dr_s[j];
    end
  end

  // signed angles and mapping numerators
  always_comb begin
    logic [DEG_W-1:0]        mp;
    logic [DEG_W-1:0]        mr;
    logic signed [ANG_W-1:0] ap;
    logic signed [ANG_W-1:0] ar;
    logic signed [NUM_W-1:0] ls;
    logic signed [NUM_W-1:0] gm;
    logic signed [NUM_W-1:0] ds;
    logic signed [NUM_W-1:0] nc;
    logic signed [NUM_W-1:0] nr;
    nxt[S_MAP] = st_q[S_MAP-1];
    mp = st_q[S_MAP-1].full_p ? DEG_W'(DEG_FULL) : st_q[S_MAP-1].dp;
    mr = st_q[S_MAP-1].full_r ? DEG_W'(DEG_FULL) : st_q[S_MAP-1].dr;
    ap = st_q[S_MAP-1].neg_x ? -ANG_W'(mp) : ANG_W'(mp);
    ar = st_q[S_MAP-1].neg_y ? -ANG_W'(mr) : ANG_W'(mr);
    ls = NUM_W'(lim_eff);
    gm = NUM_W'(GRID_SIZE - 1);
    ds = NUM_W'({lim_eff, 1'b0});
    nc = (NUM_W'(ar) + ls) * gm;
    nr = (NUM_W'(ap) + ls) * gm;
    nxt[S_MAP].pitch = ap;
    nxt[S_MAP].roll  = ar;
    nxt[S_MAP].num_c = nc;
    nxt[S_MAP].num_r = nr;
    nxt[S_MAP].den   = ds;
    nxt[S_MAP].lo_c  = nc <= -ds;
    nxt[S_MAP].lo_r  = nr <= -ds;
    nxt[S_MAP].hi_c  = nc >= NUM_W'(GRID_SIZE) * ds;
    nxt[S_MAP].hi_r  = nr >= NUM_W'(GRID_SIZE) * ds;
    nxt[S_MAP].ic    = '0;
    nxt[S_MAP].ir    = '0;
  end

  // grid index search: largest t below GRID_SIZE with t*den <= num
  for (genvar j = 0; j < IW; j++) begin : g_idx
    localparam int K = S_MAP + 1 + j;
    always_comb begin
      logic [IW-1:0]           tc;
      logic [IW-1:0]           tr;
      logic signed [NUM_W-1:0] tcs;
      logic signed [NUM_W-1:0] trs;
      nxt[K] = st_q[K-1];
      tc = st_q[K-1].ic | IW'(1 << (IW - 1 - j));
      tr = st_q[K-1].ir | IW'(1 << (IW - 1 - j));
      tcs = NUM_W'(tc);
      trs = NUM_W'(tr);
      if ((int'(tc) <= GRID_SIZE - 1) && (st_q[K-1].num_c >= tcs * st_q[K-1].den)) begin
        nxt[K].ic = tc;
      end
      if ((int'(tr) <= GRID_SIZE - 1) && (st_q[K-1].num_r >= trs * st_q[K-1].den)) begin
        nxt[K].ir = tr;
      end
    end
  end

  // output from the last stage register
  pipe_t last;
  assign last = st_q[NSTG-1];
  assign out_valid_o = v_q[NSTG-1];

  always_comb begin
    out_data_o.pitch_deg = last.pitch;
    out_data_o.roll_deg  = last.roll;
    out_data_o.grid_col  = last.lo_c ? '0 :
                           last.hi_c ? GRID_W'(GRID_SIZE - 1) : GRID_W'(last.ic);
    out_data_o.grid_row  = last.lo_r ? '0 :
                           last.hi_r ? GRID_W'(GRID_SIZE - 1) : GRID_W'(last.ir);
    out_data_o.off_grid  = last.lo_c || last.hi_c || last.lo_r || last.hi_r;
  end

endmodule
`default_nettype wire

### rtl/core/ttgp_checker.sv
// Port-level assertions for the tilt-to-grid core, bound to the top level.
`default_nettype none
module ttgp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire ttgp_pkg::in_item_t          in_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire ttgp_pkg::out_item_t         out_data_o,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [ttgp_pkg::ADDR_W-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata,
  input wire logic                        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pitch_deg >= -8'sd90) && (out_data_o.pitch_deg <= 8'sd90)
                 && (out_data_o.roll_deg >= -8'sd90) && (out_data_o.roll_deg <= 8'sd90))
    else $error("angle outside +/-90 degrees");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind tilt_to_grid_position_core ttgp_checker u_ttgp_checker (.*);
`default_nettype wire

### tb/tb_tilt_to_grid_position_core.sv
// Testbench for tilt_to_grid_position_core: directed, register, random and backpressure tests.
`timescale 1ns / 1ps
module tb_tilt_to_grid_position_core;
  import ttgp_pkg::*;

  localparam int GRID   = 8;
  localparam int DRAIN  = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_item_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  tilt_to_grid_position_core dut (.*);

  always #5 clk_i = ~clk_i;

  longint unsigned sin_sq[1:89];
  out_item_t       pending_results[$];
  int              cur_limit = 45;
  int              errors = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              hold_left = 0;

  // sin^2 of each whole degree in Q30, by repeated one-degree rotation
  initial begin
    longint unsigned c, s, s_n, a, b;
    c = 64'd1073741824;
    s = 0;
    for (int d = 1; d <= 89; d++) begin
      a = c * 64'd1073578288;
      b = s * 64'd18739379;
      s_n = (s * 64'd1073578288 + c * 64'd18739379 + 64'd536870912) >> 30;
      c = (a >= b) ? ((a - b + 64'd536870912) >> 30) : 64'd0;
      s = s_n;
      sin_sq[d] = (s * s + 64'd536870912) >> 30;
    end
    sin_sq[30] = 64'd268435456;
    sin_sq[45] = 64'd536870912;
    sin_sq[60] = 64'd805306368;
  end

  function automatic int tilt_degrees(longint unsigned n2, longint unsigned total);
    logic [127:0] lhs, rhs;
    int deg;
    deg = 0;
    if (total == 0 || n2 == 0) return 0;
    lhs = {64'd0, n2} << 30;
    for (int d = 1; d <= 89; d++) begin
      rhs = {64'd0, total} * {64'd0, sin_sq[d]};
      if (lhs < rhs) return deg;
      deg = d;
    end
    if (n2 == total) deg = 90;
    return deg;
  endfunction

  function automatic int grid_index(int ang, int lim, ref bit off);
    int idx;
    idx = ((ang + lim) * (GRID - 1)) / (2 * lim);
    if (idx < 0) begin
      off = 1'b1;
      idx = 0;
    end else if (idx > GRID - 1) begin
      off = 1'b1;
      idx = GRID - 1;
    end
    return idx;
  endfunction

  function automatic out_item_t predict_position(in_item_t it, int limit);
    longint signed x, y, z;
    longint unsigned x2, y2, z2, total;
    int pitch, roll, lim;
    bit off;
    out_item_t r;
    x = it.accel_x;
    y = it.accel_y;
    z = it.accel_z;
    x2 = x * x;
    y2 = y * y;
    z2 = z * z;
    total = x2 + y2 + z2;
    pitch = tilt_degrees(x2, total);
    roll = tilt_degrees(y2, total);
    if (x < 0) pitch = -pitch;
    if (y < 0) roll = -roll;
    lim = limit & 8'h7F;
    if (lim == 0) lim = 1;
    off = 1'b0;
    r.grid_col = GRID_W'(grid_index(roll, lim, off));
    r.grid_row = GRID_W'(grid_index(pitch, lim, off));
    r.pitch_deg = pitch[7:0];
    r.roll_deg = roll[7:0];
    r.off_grid = off;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, or later when idle_pct adds idle gaps
  task automatic send_sample(in_item_t it);
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_position(it, cur_limit));
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
  endtask

  task automatic sample_xyz(int x, int y, int z);
    in_item_t it;
    it.accel_x = x[15:0];
    it.accel_y = y[15:0];
    it.accel_z = z[15:0];
    send_sample(it);
  endtask

  function automatic in_item_t random_sample();
    in_item_t it;
    int m;
    it = 48'({$urandom, $urandom});
    case ($urandom_range(5))
      0: it.accel_x = 16'($signed($urandom_range(0, 40)) - 20);
      1: begin
        it.accel_y = '0;
        it.accel_z = '0;
      end
      2: begin
        m = $urandom_range(1, 20000);
        it.accel_x = 16'(m);
        it.accel_z = $urandom_range(1) ? 16'(m) : 16'(-m);
      end
      3: begin
        it.accel_x = $signed(it.accel_x) >>> $urandom_range(15);
        it.accel_y = $signed(it.accel_y) >>> $urandom_range(15);
        it.accel_z = $signed(it.accel_z) >>> $urandom_range(15);
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == '0) cur_limit = data & 32'h7F;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_random(int n);
    repeat (n) send_sample(random_sample());
  endtask

  task automatic test_directed();
    sample_xyz(0, 0, 0);
    sample_xyz(0, 0, 16384);
    sample_xyz(32767, 0, 0);
    sample_xyz(-32768, 0, 0);
    sample_xyz(0, 32767, 0);
    sample_xyz(0, -32768, 0);
    sample_xyz(-32768, -32768, -32768);
    sample_xyz(32767, 32767, 32767);
    sample_xyz(1000, 0, 1000);
    sample_xyz(-1000, 1000, 0);
    sample_xyz(1, 0, 2);
    sample_xyz(1, 1, -1);
    sample_xyz(-1, 0, 100);
    sample_xyz(3, -2, 32767);
    sample_xyz(100, 0, 173);
    sample_xyz(0, 0, -32768);
    wait_drained();
  endtask

  task automatic test_limits();
    int lims[6] = '{0, 1, 90, 127, 7, 45};
    foreach (lims[i]) begin
      write_reg(3'd0, 32'hFFFF_FF80 | lims[i]);
      sample_xyz(32767, -32768, 0);
      sample_xyz(-2000, 2000, 30000);
      send_random(40);
      wait_drained();
    end
    // unmapped address must leave angle_limit alone
    write_reg(3'd4, 32'd3);
    send_random(20);
    wait_drained();
  endtask

  task automatic test_idle_phases();
    int idle[4] = '{0, 62, 0, 17};
    int stall[4] = '{0, 0, 62, 17};
    foreach (idle[i]) begin
      idle_pct = idle[i];
      stall_pct = stall[i];
      write_reg(3'd0, $urandom_range(1, 90));
      send_random(400);
      wait_drained();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_left = 200;
    send_random(60);
    wait_drained();
    // sender pauses until the pipeline is empty, then resumes
    send_random(30);
    wait_drained();
    send_random(30);
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction %p", $time, out_data_o);
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (e !== out_data_o) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_limits();
    test_idle_phases();
    test_backpressure();
    if (errors == 0) begin
      $display("tb_tilt_to_grid_position_core: clean");
    end else begin
      $display("tb_tilt_to_grid_position_core: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_tilt_to_grid_position_core: errors");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ttgp_pkg.sv
rtl/core/ttgp_deg_step.sv
rtl/core/tilt_to_grid_position_core.sv
rtl/core/ttgp_checker.sv
tb/tb_tilt_to_grid_position_core.sv
